### rtl/pli_pkg.sv
// Shared types and constants for the piecewise linear interpolator.
// No dependencies; used by the interpolator and the divider.
package pli_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int DATA_W      = 32;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int COUNT_W     = 7;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd2;
    localparam logic [DATA_W:0]    ONE_Q16     = 33'h0_0001_0000;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage

### rtl/piecewise_linear_interpolator.sv
// Piecewise linear interpolator: breakpoint tables in RAM, scan sequencer,
// one multiplier and a serial divider. Depends on pli_pkg, pli_ram, pli_divider.
//
// The input channel carries load and query transactions (valid/ready).
// A load writes one (key, value) pair of signed Q16.16 into a table slot;
// it produces no result. A query scans entries 0 to entry_count-1 one per
// cycle through the key and value RAM read ports, looking for an exact key,
// the first bracketing pair and the smallest key. An exact hit finishes as
// soon as it is read; otherwise the scan runs to the end. An interpolation
// then passes through the multiplier state and the serial divider.
// The block takes one transaction at a time; input ready is high only when
// no query is in progress. Results sit in an output register, so the next
// transaction is accepted while a result waits; a finished query holds until
// that register is free when the receiver stalls.
// The user writes entry_count through the configuration port only while idle;
// the block does not enforce this, and the scan clamps it to 2 to 64. Reset
// returns it to 2, empties the output register; tables are unset until loaded.
module piecewise_linear_interpolator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pli_pkg::COUNT_W-1:0]         i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_action,
    input  logic [pli_pkg::IDX_W-1:0]           i_entry_index,
    input  logic signed [pli_pkg::DATA_W-1:0]   i_key,
    input  logic signed [pli_pkg::DATA_W-1:0]   i_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [pli_pkg::DATA_W-1:0]   o_result,
    output logic                                o_out_of_range,
    output logic                                o_exact_hit
);

    localparam int W = pli_pkg::DATA_W;

    pli_pkg::t_state r_state, n_state;

    logic [pli_pkg::COUNT_W-1:0] r_entry_count;
    logic [pli_pkg::IDX_W-1:0]   n_last;
    logic [pli_pkg::IDX_W-1:0]   r_idx;
    logic [pli_pkg::IDX_W-1:0]   n_addr;
    logic                        n_accept;
    logic                        n_we;

    logic [W-1:0]        rd_key_raw, rd_val_raw;
    logic signed [W-1:0] rd_key, rd_val;

    logic signed [W-1:0] r_query;
    logic signed [W-1:0] r_prev_key, r_prev_val;
    logic signed [W-1:0] r_k0, r_k1, r_v0, r_v1;
    logic signed [W-1:0] r_min;
    logic signed [W-1:0] n_min;
    logic                r_br_found;
    logic                n_hit, n_bracket;

    logic signed [W-1:0] r_res;
    logic                r_res_oor, r_res_hit;
    logic                r_neg;

    logic signed [W:0]   n_min_less;
    logic signed [W:0]   n_dv;
    logic [W-1:0]        n_mag, n_dq, n_dk;
    logic [2*W-1:0]      n_prod;
    logic                div_start, div_done;
    logic [W-1:0]        div_quo;

    logic                r_out_valid;
    logic signed [W-1:0] r_out_result;
    logic                r_out_oor, r_out_hit;
    logic                n_out_free;

    always_comb begin
        if (r_entry_count < pli_pkg::COUNT_W'(2)) begin
            n_last = pli_pkg::IDX_W'(1);
        end else if (r_entry_count >= pli_pkg::COUNT_W'(pli_pkg::MAX_ENTRIES)) begin
            n_last = pli_pkg::IDX_W'(pli_pkg::MAX_ENTRIES - 1);
        end else begin
            n_last = pli_pkg::IDX_W'(r_entry_count - 1'b1);
        end
    end

    assign o_in_ready = (r_state == pli_pkg::ST_IDLE);
    assign n_accept   = i_in_valid && o_in_ready;
    assign n_we       = n_accept && (i_action == pli_pkg::ACT_LOAD);
    assign n_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        if (r_state == pli_pkg::ST_IDLE) begin
            n_addr = (i_action == pli_pkg::ACT_LOAD) ? i_entry_index : '0;
        end else begin
            n_addr = r_idx + 1'b1;
        end
    end

    pli_ram #(.WIDTH(W), .DEPTH(pli_pkg::MAX_ENTRIES)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (n_we),
        .i_addr  (n_addr),
        .i_wdata (i_key),
        .o_rdata (rd_key_raw)
    );

    pli_ram #(.WIDTH(W), .DEPTH(pli_pkg::MAX_ENTRIES)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (n_we),
        .i_addr  (n_addr),
        .i_wdata (i_value),
        .o_rdata (rd_val_raw)
    );

    assign rd_key = signed'(rd_key_raw);
    assign rd_val = signed'(rd_val_raw);

    assign n_hit     = (rd_key == r_query);
    assign n_bracket = (r_idx != '0) && !r_br_found &&
                       (r_prev_key < r_query) && (r_query < rd_key);
    assign n_min     = ((r_idx == '0) || (rd_key < r_min)) ? rd_key : r_min;
    assign n_min_less = {n_min[W-1], n_min} - signed'(pli_pkg::ONE_Q16);

    assign n_dq   = W'({r_query[W-1], r_query} - {r_k0[W-1], r_k0});
    assign n_dk   = W'({r_k1[W-1], r_k1} - {r_k0[W-1], r_k0});
    assign n_dv   = {r_v1[W-1], r_v1} - {r_v0[W-1], r_v0};
    assign n_mag  = n_dv[W] ? W'(-n_dv) : n_dv[W-1:0];
    assign n_prod = {{W{1'b0}}, n_mag} * {{W{1'b0}}, n_dq};

    assign div_start = (r_state == pli_pkg::ST_MUL);

    pli_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (n_prod),
        .i_divisor  (n_dk),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pli_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pli_pkg::ST_IDLE: begin
                if (n_accept && i_action == pli_pkg::ACT_QUERY) begin
                    n_state = pli_pkg::ST_SCAN;
                end
            end
            pli_pkg::ST_SCAN: begin
                if (n_hit) begin
                    n_state = pli_pkg::ST_DONE;
                end else if (r_idx == n_last) begin
                    n_state = (r_br_found || n_bracket) ? pli_pkg::ST_MUL : pli_pkg::ST_DONE;
                end
            end
            pli_pkg::ST_MUL: begin
                n_state = pli_pkg::ST_DIV;
            end
            pli_pkg::ST_DIV: begin
                if (div_done) begin
                    n_state = pli_pkg::ST_DONE;
                end
            end
            pli_pkg::ST_DONE: begin
                if (n_out_free) begin
                    n_state = pli_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pli_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            pli_pkg::ST_IDLE: begin
                r_query    <= i_key;
                r_idx      <= '0;
                r_br_found <= 1'b0;
            end
            pli_pkg::ST_SCAN: begin
                r_idx      <= r_idx + 1'b1;
                r_prev_key <= rd_key;
                r_prev_val <= rd_val;
                r_min      <= n_min;
                if (n_bracket) begin
                    r_br_found <= 1'b1;
                    r_k0       <= r_prev_key;
                    r_v0       <= r_prev_val;
                    r_k1       <= rd_key;
                    r_v1       <= rd_val;
                end
                if (n_hit) begin
                    r_res     <= rd_val;
                    r_res_hit <= 1'b1;
                    r_res_oor <= 1'b0;
                end else begin
                    r_res_hit <= 1'b0;
                    r_res_oor <= 1'b1;
                    if (n_min_less[W] != n_min_less[W-1]) begin
                        r_res <= {1'b1, {(W-1){1'b0}}};
                    end else begin
                        r_res <= n_min_less[W-1:0];
                    end
                end
            end
            pli_pkg::ST_MUL: begin
                r_neg     <= n_dv[W];
                r_res_hit <= 1'b0;
                r_res_oor <= 1'b0;
            end
            pli_pkg::ST_DIV: begin
                if (div_done) begin
                    r_res <= r_neg ? (r_v0 - signed'(div_quo)) : (r_v0 + signed'(div_quo));
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= pli_pkg::COUNT_RESET;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_entry_count <= i_cfg_data;
            end
            if (r_state == pli_pkg::ST_DONE && n_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == pli_pkg::ST_DONE && n_out_free) begin
            r_out_result <= r_res;
            r_out_oor    <= r_res_oor;
            r_out_hit    <= r_res_hit;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result       = r_out_result;
    assign o_out_of_range = r_out_oor;
    assign o_exact_hit    = r_out_hit;

endmodule

### rtl/pli_ram.sv
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module pli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/pli_divider.sv
// Serial restoring divider, one quotient bit per cycle.
// Depends on pli_pkg. The dividend's upper half must be below the divisor.
module pli_divider (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [2*pli_pkg::DATA_W-1:0]   i_dividend,
    input  logic [pli_pkg::DATA_W-1:0]     i_divisor,
    output logic                           o_done,
    output logic [pli_pkg::DATA_W-1:0]     o_quotient
);

    localparam int CNT_W = $clog2(pli_pkg::DATA_W);

    logic                        r_busy;
    logic                        r_done;
    logic [CNT_W-1:0]            r_cnt;
    logic [pli_pkg::DATA_W-1:0]  r_rem;
    logic [pli_pkg::DATA_W-1:0]  r_low;
    logic [pli_pkg::DATA_W-1:0]  r_div;
    logic [pli_pkg::DATA_W:0]    n_trial;
    logic                        n_fits;

    assign n_trial = {r_rem, r_low[pli_pkg::DATA_W-1]};
    assign n_fits  = n_trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNT_W'(pli_pkg::DATA_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[2*pli_pkg::DATA_W-1:pli_pkg::DATA_W];
            r_low <= i_dividend[pli_pkg::DATA_W-1:0];
            r_div <= i_divisor;
            r_cnt <= '0;
        end else if (r_busy) begin
            if (n_fits) begin
                r_rem <= pli_pkg::DATA_W'(n_trial - {1'b0, r_div});
            end else begin
                r_rem <= n_trial[pli_pkg::DATA_W-1:0];
            end
            r_low <= {r_low[pli_pkg::DATA_W-2:0], n_fits};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_low;

endmodule
